FILE: rtl/ttcw_pkg.sv
// Shared types and constants for the text terminal cell writer.
// No dependencies; imported by every module except ttcw_ram.
`timescale 1ns / 1ps

package ttcw_pkg;

   localparam int CHAR_W   = 8;
   localparam int COLOR_W  = 8;
   localparam int CELL_W   = 16;
   localparam int INDEX_W  = 11;
   localparam int CURSOR_W = 11;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;
   localparam logic [CELL_W-1:0]  CELL_RESET  = {COLOR_RESET, CH_SPACE};

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // request classes decided by the front end
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_CHAR      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NEWLINE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BACKSPACE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TAB       = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ      = 3'd4;

   typedef struct packed {
      logic               op;
      logic [CHAR_W-1:0]  char_code;
      logic [INDEX_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_offset;
      logic [CELL_W-1:0]   read_data;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHAR_W-1:0]  char_code;
      logic [INDEX_W-1:0] cell_index;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic init_busy;
   } back_status_type;

endpackage

FILE: rtl/ttcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module ttcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ttcw_front.sv
// Front end: takes requests, classifies put characters, holds a two-entry queue.
// Depends on ttcw_pkg.
`timescale 1ns / 1ps

module ttcw_front
   import ttcw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_type         req_data,
   input  back_status_type back_status,
   output logic            cmd_valid,
   output cmd_type         cmd
);

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   cmd_type     classified;

   function automatic cmd_type classify(input req_type r);
      cmd_type c;
      c.char_code  = r.char_code;
      c.cell_index = r.cell_index;
      if (r.op == OP_READ) begin
         c.kind = KIND_READ;
      end else begin
         case (r.char_code)
            CH_NEWLINE:   c.kind = KIND_NEWLINE;
            CH_BACKSPACE: c.kind = KIND_BACKSPACE;
            CH_TAB:       c.kind = KIND_TAB;
            default:      c.kind = KIND_CHAR;
         endcase
      end
      return c;
   endfunction

   assign busy       = (count_ff == 2'd2) || back_status.init_busy;
   assign push       = start && !busy;
   assign classified = classify(req_data);
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (back_status.pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !back_status.pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && back_status.pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

FILE: rtl/ttcw_back.sv
// Back end: cursor update, screen store access, scroll copy and clearing pass.
// Depends on ttcw_pkg and ttcw_ram.
`timescale 1ns / 1ps

module ttcw_back
   import ttcw_pkg::*;
#(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  cmd_type            cmd,
   input  logic [COLOR_W-1:0] cell_color,
   output back_status_type    back_status,
   output logic               rsp_strobe,
   output rsp_type            rsp_data
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int PH_W       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
   localparam int CW         = COL_W + 5;
   localparam int RW         = ROW_W + 1;

   localparam logic [2:0] ST_INIT      = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_READ_WAIT = 3'd2;
   localparam logic [2:0] ST_COPY      = 3'd3;
   localparam logic [2:0] ST_COPY_LAST = 3'd4;
   localparam logic [2:0] ST_CLEAR     = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [PH_W-1:0]   phase_ff, phase_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic              pend_ff, pend_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CW-1:0]     col_t;
   logic [RW-1:0]     row_t;
   logic [PH_W-1:0]   ph_t;
   logic              scroll;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data, rd_data;

   function automatic logic [ADDR_W-1:0] lin(input logic [ROW_W-1:0] r,
                                            input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
   endfunction

   // cursor after a put; phase tracks col modulo TAB_STOP
   always_comb begin
      col_t  = CW'(col_ff);
      row_t  = RW'(row_ff);
      ph_t   = phase_ff;
      scroll = 1'b0;
      case (cmd.kind)
         KIND_NEWLINE: begin
            row_t = row_t + RW'(1);
            col_t = '0;
            ph_t  = '0;
         end
         KIND_BACKSPACE: begin
            if (col_ff != '0) begin
               col_t = col_t - CW'(1);
               ph_t  = (phase_ff == '0) ? PH_W'(TAB_STOP - 1) : phase_ff - PH_W'(1);
            end
         end
         KIND_TAB: begin
            col_t = col_t + CW'(TAB_STOP) - CW'(phase_ff);
            ph_t  = '0;
         end
         default: begin
            col_t = col_t + CW'(1);
            ph_t  = (phase_ff == PH_W'(TAB_STOP - 1)) ? '0 : phase_ff + PH_W'(1);
         end
      endcase
      if (col_t >= CW'(COLUMNS)) begin
         col_t = '0;
         ph_t  = '0;
         row_t = row_t + RW'(1);
      end
      if (row_t >= RW'(ROWS)) begin
         scroll = 1'b1;
         row_t  = RW'(ROWS - 1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      phase_in      = phase_ff;
      addr_in       = addr_ff;
      dst_in        = dst_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = {cell_color, CH_SPACE};
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      back_status.pop       = 1'b0;
      back_status.init_busy = (state_ff == ST_INIT);
      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = CELL_RESET;
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               back_status.pop = 1'b1;
               if (cmd.kind == KIND_READ) begin
                  if (32'(cmd.cell_index) < 32'(CELL_COUNT)) begin
                     rd_en    = 1'b1;
                     rd_addr  = ADDR_W'(cmd.cell_index);
                     state_in = ST_READ_WAIT;
                  end else begin
                     rsp_strobe_in        = 1'b1;
                     rsp_in.cursor_offset = CURSOR_W'(lin(row_ff, col_ff));
                     rsp_in.read_data     = '0;
                  end
               end else begin
                  if (cmd.kind == KIND_CHAR) begin
                     wr_en   = 1'b1;
                     wr_addr = lin(row_ff, col_ff);
                     wr_data = {cell_color, cmd.char_code};
                  end
                  row_in   = ROW_W'(row_t);
                  col_in   = COL_W'(col_t);
                  phase_in = ph_t;
                  rsp_in.cursor_offset = CURSOR_W'(lin(ROW_W'(row_t), COL_W'(col_t)));
                  rsp_in.read_data     = '0;
                  if (scroll) begin
                     addr_in  = ADDR_W'(COLUMNS);
                     pend_in  = 1'b0;
                     state_in = ST_COPY;
                  end else begin
                     rsp_strobe_in = 1'b1;
                  end
               end
            end
         end
         ST_READ_WAIT: begin
            rsp_strobe_in        = 1'b1;
            rsp_in.cursor_offset = CURSOR_W'(lin(row_ff, col_ff));
            rsp_in.read_data     = rd_data;
            state_in             = ST_IDLE;
         end
         ST_COPY: begin
            // read one row down, write the previous read one row up
            rd_en   = 1'b1;
            wr_en   = pend_ff;
            wr_addr = dst_ff;
            wr_data = rd_data;
            dst_in  = addr_ff - ADDR_W'(COLUMNS);
            pend_in = 1'b1;
            if (addr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = ST_COPY_LAST;
            end else begin
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         ST_COPY_LAST: begin
            wr_en    = 1'b1;
            wr_addr  = dst_ff;
            wr_data  = rd_data;
            addr_in  = ADDR_W'(CELL_COUNT - COLUMNS);
            state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + ADDR_W'(1);
            if (addr_ff == ADDR_W'(CELL_COUNT - 1)) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         row_ff        <= '0;
         col_ff        <= '0;
         phase_ff      <= '0;
         addr_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         phase_ff      <= phase_in;
         addr_ff       <= addr_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_ff <= dst_in;
      rsp_ff <= rsp_in;
   end

   ttcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < 32'(ROWS)) && (32'(col_ff) < 32'(COLUMNS)))
      else $error("cursor outside the screen");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < 32'(CELL_COUNT)))
      else $error("screen write beyond the store");

   a_scroll_on_bottom: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (32'(row_ff) == 32'(ROWS - 1)))
      else $error("scroll with cursor off the bottom row");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(state_ff) == ST_IDLE || $past(state_ff) == ST_READ_WAIT
                         || $past(state_ff) == ST_CLEAR))
      else $error("response from an unexpected state");

endmodule

FILE: rtl/text_terminal_cell_writer.sv
// Text terminal cell writer top level: color register, front end and back end.
// Depends on ttcw_pkg, ttcw_front, ttcw_back (and ttcw_ram below it).
//
// Usage:
//   Request channel: drive req_data and raise start; the request is taken at a
//   clock edge where start is high and busy is low. op = put writes or moves
//   the cursor for char_code, op = read fetches the cell at cell_index.
//   Response channel: rsp_strobe is high for one cycle per request, in request
//   order, with the cursor offset and (for reads) the cell. The receiver
//   cannot stall; every strobe must be taken.
//   Color register: csr_write_enable / csr_write_data load the attribute byte
//   (reset value 0x07); write it only while no request is in flight.
// Timing:
//   A put is answered via the queue entry and the response register; a read also
//   waits in ST_READ_WAIT on the registered RAM read, the back end popping nothing.
//   Back to back puts sustain one per cycle while none scrolls. A put that scrolls
//   holds the back end (one cell moved per cycle through the single RAM port pair,
//   then the bottom row cleared); the two-entry queue then fills and busy rises.
// Reset:
//   After reset a clearing pass writes spaces in color 0x07 to all
//   ROWS*COLUMNS cells (2000 by default); busy is high meanwhile.
`timescale 1ns / 1ps

module text_terminal_cell_writer
   import ttcw_pkg::*;
#(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               csr_write_enable,
   input  logic [COLOR_W-1:0] csr_write_data
);

   logic [COLOR_W-1:0] color_ff;
   logic               cmd_valid;
   cmd_type            cmd;
   back_status_type    back_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= COLOR_RESET;
      end else if (csr_write_enable) begin
         color_ff <= csr_write_data;
      end
   end

   ttcw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .back_status (back_status),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd)
   );

   ttcw_back #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cell_color  (color_ff),
      .back_status (back_status),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: tb/text_terminal_cell_writer_tb.sv
// Self-checking testbench for text_terminal_cell_writer: character puts, cell reads and color writes.
// A shadow screen, cursor and attribute byte predict every response.
// Depends on ttcw_pkg and the RTL of the block.
`timescale 1ns / 1ps

module text_terminal_cell_writer_tb;
   import ttcw_pkg::*;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int TAB_STOP      = 4;
   localparam int CELL_COUNT    = COLUMNS * ROWS;
   // a scroll moves every row but the top one up through one port pair
   localparam int SETTLE_CYCLES = CELL_COUNT + 100;
   localparam int STALL_LIMIT   = 20000;
   localparam int REPORT_MAX    = 10;
   localparam int PHASE_ITEMS   = 650;
   localparam int REQ_W         = $bits(req_type);

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_data = '0;
   logic               rsp_strobe;
   rsp_type            rsp_data;
   logic               csr_write_enable = 1'b0;
   logic [COLOR_W-1:0] csr_write_data = '0;

   req_type            request_q[$];
   rsp_type            cursor_and_cell_q[$];
   rsp_type            oldest_rsp;
   int                 idle_pct = 34;
   int                 fault_count = 0;
   int                 stall_cycles = 0;

   // shadow terminal
   logic [CELL_W-1:0]  screen_image [0:CELL_COUNT-1];
   logic [COLOR_W-1:0] attr_byte;
   int                 line_no;
   int                 column_no;

   text_terminal_cell_writer #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data         (req_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // applies one request to the shadow terminal, returns the expected response
   function automatic rsp_type advance_terminal(input req_type r);
      rsp_type res;
      int      pos;
      int      i;
      res = '0;
      if (r.op == OP_PUT) begin
         case (r.char_code)
            CH_NEWLINE: begin
               line_no++;
               column_no = 0;
            end
            CH_BACKSPACE: begin
               if (column_no > 0) column_no--;
            end
            CH_TAB: begin
               column_no += TAB_STOP - (column_no % TAB_STOP);
            end
            default: begin
               pos = line_no * COLUMNS + column_no;
               if (pos < CELL_COUNT) screen_image[pos] = {attr_byte, r.char_code};
               column_no++;
            end
         endcase
         if (column_no >= COLUMNS) begin
            column_no = 0;
            line_no++;
         end
         if (line_no >= ROWS) begin
            for (i = COLUMNS; i < CELL_COUNT; i++) screen_image[i - COLUMNS] = screen_image[i];
            for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
               screen_image[i] = {attr_byte, CH_SPACE};
            line_no = ROWS - 1;
         end
      end else if (r.cell_index < CELL_COUNT) begin
         res.read_data = screen_image[r.cell_index];
      end
      res.cursor_offset = CURSOR_W'(line_no * COLUMNS + column_no);
      return res;
   endfunction

   task automatic add_put(input logic [CHAR_W-1:0] ch);
      req_type r;
      r.op = OP_PUT;
      r.char_code = ch;
      r.cell_index = INDEX_W'($urandom_range(2047));
      request_q.push_back(r);
   endtask

   task automatic add_read(input int idx);
      req_type r;
      r.op = OP_READ;
      r.char_code = CHAR_W'($urandom_range(255));
      r.cell_index = INDEX_W'(idx);
      request_q.push_back(r);
   endtask

   function automatic logic [CHAR_W-1:0] text_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 84) return CHAR_W'($urandom_range(32, 126));
      else if (pick < 88) return CH_TAB;
      else if (pick < 92) return CH_BACKSPACE;
      else if (pick < 93) return CH_NEWLINE;
      else return CHAR_W'($urandom_range(255));
   endfunction

   function automatic int cell_pick();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) return $urandom_range(CELL_COUNT - 1);
      else if (pick < 70) return $urandom_range(CELL_COUNT - COLUMNS, CELL_COUNT - 1);
      else if (pick < 85) return $urandom_range(COLUMNS - 1);
      else return $urandom_range(2047);
   endfunction

   // mostly lines of text with reads mixed in, some blank-line runs and noise
   task automatic queue_terminal_traffic(input int n);
      int pick;
      int len;
      req_type r;
      while (request_q.size() < n) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            len = $urandom_range(100);
            repeat (len) add_put(text_byte());
            if ($urandom_range(1)) add_put(CH_NEWLINE);
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 4)) add_read(cell_pick());
         end else if (pick < 93) begin
            repeat ($urandom_range(1, 20)) add_put(CH_NEWLINE);
         end else begin
            repeat ($urandom_range(1, 8)) begin
               r = req_type'(REQ_W'($urandom));
               request_q.push_back(r);
            end
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (request_q.size() != 0 || start || cursor_and_cell_q.size() != 0);
   endtask

   // only called once the block has gone quiet
   task automatic write_color(input logic [COLOR_W-1:0] value);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      attr_byte = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_data <= request_q.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // response monitor; prediction happens here so acceptance and checking share one order
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) cursor_and_cell_q.push_back(advance_terminal(req_data));
         if (rsp_strobe) begin
            if (cursor_and_cell_q.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_MAX)
                  $display("unexpected response: cursor %0d cell %h",
                           rsp_data.cursor_offset, rsp_data.read_data);
            end else begin
               oldest_rsp = cursor_and_cell_q.pop_front();
               if (rsp_data.cursor_offset !== oldest_rsp.cursor_offset ||
                   rsp_data.read_data !== oldest_rsp.read_data) begin
                  fault_count++;
                  if (fault_count <= REPORT_MAX)
                     $display("mismatch: cursor exp %0d got %0d, cell exp %h got %h",
                              oldest_rsp.cursor_offset, rsp_data.cursor_offset,
                              oldest_rsp.read_data, rsp_data.read_data);
               end
            end
         end
      end
   end

   // watchdog: long stretch with no request or response taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL text_terminal_cell_writer");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < CELL_COUNT; i++) screen_image[i] = CELL_RESET;
      attr_byte = COLOR_RESET;
      line_no = 0;
      column_no = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, range edges, control bytes, raw bytes
      add_read(0);
      add_read(CELL_COUNT - 1);
      add_read(CELL_COUNT);
      add_read(2047);
      add_put(8'h00);
      add_put(8'hFF);
      add_put(8'h41);
      add_put(CH_BACKSPACE);
      add_read(1);
      add_read(2);
      add_put(CH_NEWLINE);
      add_put(CH_BACKSPACE);     // already at column 0
      add_put(CH_TAB);
      add_put(8'h0D);
      add_put(CH_TAB);
      add_put(CH_TAB);
      add_read(COLUMNS + 4);
      add_read(COLUMNS);
      wait_drained();

      write_color(8'hFF);
      idle_pct = 34;
      queue_terminal_traffic(PHASE_ITEMS);
      wait_drained();

      write_color(8'h00);
      idle_pct = 88;
      queue_terminal_traffic(PHASE_ITEMS);
      wait_drained();

      write_color(COLOR_W'($urandom_range(1, 254)));
      idle_pct = 0;
      queue_terminal_traffic(PHASE_ITEMS);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("PASS text_terminal_cell_writer");
      end else begin
         $display("FAIL text_terminal_cell_writer");
      end
      $finish;
   end

endmodule

FILE: text_terminal_cell_writer.f
rtl/ttcw_pkg.sv
rtl/ttcw_ram.sv
rtl/ttcw_front.sv
rtl/ttcw_back.sv
rtl/text_terminal_cell_writer.sv
tb/text_terminal_cell_writer_tb.sv
